// ===== sv/locd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locd_pkg
// Shared constants and status codes of the lock order cycle detector.
// ----------------------------------------------------------------------------
package locd_pkg;

    localparam int LOCKS_DEF       = 64;
    localparam int THREADS_DEF     = 8;
    localparam int STACK_DEPTH_DEF = 16;

    localparam int MODE_W   = 1;
    localparam int THREAD_W = 3;
    localparam int LOCK_W   = 6;
    localparam int STATUS_W = 3;
    localparam int HELD_W   = 5;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_MULTI_UNL = 3'd1,
        ST_INV_UNL   = 3'd2,
        ST_DEADLOCK  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_HALTED    = 3'd5
    } t_status;

    localparam logic MODE_ACQ = 1'b0;
    localparam logic MODE_REL = 1'b1;

endpackage

// ===== sv/locd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module locd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lock_order_cycle_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_order_cycle_detector_unit
// Lock order checker: per-thread lock stacks in RAM, order graph as an
// adjacency matrix in RAM, cycle check by an iterative depth-first search.
// ----------------------------------------------------------------------------
// sequence: accept, S_TOP, S_DEC, S_DONE for a release, a halted item, an overflow or an
//   acquire with an empty stack or of the top lock; S_MROW precedes S_DONE if the edge exists
// a new edge adds a depth-first search over S_ROOT, S_RD, S_SCAN and S_POP; no receiver stall
// throughput: one item at a time; busy is high from accept to result
// reset: synchronous active low; clears levels and flags, then clears the matrix row by row
module lock_order_cycle_detector_unit #(
    parameter int LOCKS       = locd_pkg::LOCKS_DEF,
    parameter int THREADS     = locd_pkg::THREADS_DEF,
    parameter int STACK_DEPTH = locd_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [locd_pkg::MODE_W-1:0]   i_mode,
    input  logic [locd_pkg::THREAD_W-1:0] i_thread_id,
    input  logic [locd_pkg::LOCK_W-1:0]   i_lock_id,
    output logic                          o_valid,
    output logic [locd_pkg::STATUS_W-1:0] o_status,
    output logic                          o_edge_added,
    output logic [locd_pkg::HELD_W-1:0]   o_held_count
);

    localparam int LW  = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int DW  = $clog2(LOCKS + 1);
    localparam int HSD = THREADS * STACK_DEPTH;
    localparam int HAW = $clog2(HSD);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_TOP   = 11'b00000000100,
        S_DEC   = 11'b00000001000,
        S_MROW  = 11'b00000010000,
        S_EDGE  = 11'b00000100000,
        S_ROOT  = 11'b00001000000,
        S_RD    = 11'b00010000000,
        S_SCAN  = 11'b00100000000,
        S_POP   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_level [THREADS];
    logic [LOCKS-1:0]      r_visited, r_finished;
    logic                  r_halted;
    logic                  r_mode;
    logic [TW-1:0]         r_thr;
    logic [LW-1:0]         r_lock, r_prev, r_root, r_here;
    logic [DW-1:0]         r_depth;
    logic [LOCKS-1:0]      r_row;
    logic                  r_edge;
    logic                  r_valid;
    logic [locd_pkg::STATUS_W-1:0] r_status;
    logic [locd_pkg::HELD_W-1:0]   r_held;
    logic [LW-1:0]         r_clr;

    // memory ports
    logic             m_we;
    logic [LW-1:0]    m_waddr, m_raddr;
    logic [LOCKS-1:0] m_wdata, m_rdata;
    logic             h_we;
    logic [HAW-1:0]   h_waddr, h_raddr;
    logic [LW-1:0]    h_wdata, h_rdata;
    logic             p_we;
    logic [LW-1:0]    p_waddr, p_raddr, p_wdata, p_rdata;

    locd_ram #(.WIDTH(LOCKS), .DEPTH(LOCKS)) u_matrix (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));
    locd_ram #(.WIDTH(LW), .DEPTH(HSD)) u_held (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata));
    locd_ram #(.WIDTH(LW), .DEPTH(LOCKS)) u_path (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata));

    // input field reduction by constant tables
    logic [TW-1:0] in_thr;
    logic [LW-1:0] in_lock;
    always_comb begin
        in_thr  = '0;
        in_lock = '0;
        for (int k = 0; k < (1 << locd_pkg::THREAD_W); k++) begin
            if (i_thread_id == locd_pkg::THREAD_W'(k)) in_thr = TW'(k % THREADS);
        end
        for (int k = 0; k < (1 << locd_pkg::LOCK_W); k++) begin
            if (i_lock_id == locd_pkg::LOCK_W'(k)) in_lock = LW'(k % LOCKS);
        end
    end

    logic [CW-1:0] cur_level;
    assign cur_level = r_level[r_thr];

    function automatic logic [HAW-1:0] hs_addr(input logic [TW-1:0] t,
                                               input logic [CW-1:0] l);
        hs_addr = HAW'(32'(t) * STACK_DEPTH + 32'(l));
    endfunction

    // first neighbor: unvisited or unfinished target
    logic [LOCKS-1:0] scan_bits;
    logic             scan_any;
    logic [LW-1:0]    scan_idx;
    assign scan_bits = r_row;
    always_comb begin
        scan_any = 1'b0;
        scan_idx = '0;
        for (int k = LOCKS - 1; k >= 0; k--) begin
            if (scan_bits[k] && (!r_visited[k] || !r_finished[k])) begin
                scan_any = 1'b1;
                scan_idx = LW'(k);
            end
        end
    end

    assign busy = (r_state != S_IDLE);
    logic accept;
    assign accept = start && !busy;

    // control path
    always_comb begin
        n_state = r_state;
        m_we = 1'b0; m_waddr = r_prev; m_wdata = m_rdata; m_raddr = r_here;
        h_we = 1'b0; h_waddr = hs_addr(r_thr, cur_level); h_wdata = r_lock;
        h_raddr = hs_addr(r_thr, cur_level - CW'(1));
        p_we = 1'b0; p_waddr = r_depth[LW-1:0]; p_wdata = r_lock;
        p_raddr = LW'(r_depth - DW'(1));
        unique case (r_state)
            S_CLEAR: begin
                m_we = 1'b1; m_waddr = r_clr; m_wdata = '0;
                if (r_clr == LW'(LOCKS - 1)) n_state = S_IDLE;
            end
            S_IDLE:  if (accept) n_state = S_TOP;
            S_TOP:   n_state = S_DEC;
            S_DEC: begin
                m_raddr = h_rdata;
                if (r_halted) n_state = S_DONE;
                else if (r_mode == locd_pkg::MODE_ACQ) begin
                    if (cur_level >= CW'(STACK_DEPTH)) n_state = S_DONE;
                    else if (cur_level == '0 || h_rdata == r_lock) begin
                        h_we = 1'b1; n_state = S_DONE;
                    end else n_state = S_MROW;
                end else n_state = S_DONE;
            end
            S_MROW: begin
                if (m_rdata[r_lock]) begin
                    h_we = 1'b1; n_state = S_DONE;
                end else begin
                    m_we = 1'b1; m_wdata = m_rdata | (LOCKS'(1) << r_lock);
                    n_state = S_ROOT;
                end
            end
            S_EDGE: n_state = S_ROOT;
            S_ROOT: begin
                if (!r_visited[r_root]) begin
                    p_we = 1'b1; p_waddr = '0; p_wdata = r_root;
                    m_raddr = r_root;
                    n_state = S_RD;
                end else if (r_root == LW'(LOCKS - 1)) begin
                    h_we = 1'b1; n_state = S_DONE;
                end
            end
            S_RD: n_state = S_SCAN;
            S_SCAN: begin
                if (scan_any && r_visited[scan_idx]) begin
                    n_state = S_DONE;
                end else if (scan_any) begin
                    p_we = 1'b1; p_waddr = r_depth[LW-1:0]; p_wdata = scan_idx;
                    m_raddr = scan_idx;
                    n_state = S_RD;
                end else begin
                    // parent sits two below the current depth
                    p_raddr = LW'(r_depth - DW'(2));
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_depth == '0) begin
                    if (r_root == LW'(LOCKS - 1)) begin
                        h_we = 1'b1; n_state = S_DONE;
                    end else n_state = S_ROOT;
                end else begin
                    m_raddr = p_rdata; n_state = S_RD;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_halted   <= 1'b0;
            r_valid    <= 1'b0;
            r_visited  <= '0;
            r_finished <= '0;
            for (int t = 0; t < THREADS; t++) r_level[t] <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + LW'(1);
                S_IDLE: if (accept) begin
                    r_mode <= i_mode; r_thr <= in_thr; r_lock <= in_lock;
                    r_edge <= 1'b0;
                end
                S_TOP: ;
                S_DEC: begin
                    r_prev <= h_rdata;
                    r_here <= h_rdata;
                    if (r_halted) r_status <= locd_pkg::ST_HALTED;
                    else if (r_mode == locd_pkg::MODE_ACQ) begin
                        if (cur_level >= CW'(STACK_DEPTH)) begin
                            r_status <= locd_pkg::ST_OVERFLOW; r_halted <= 1'b1;
                        end else begin
                            r_status <= locd_pkg::ST_OK;
                            if (cur_level == '0 || h_rdata == r_lock)
                                r_level[r_thr] <= cur_level + CW'(1);
                        end
                    end else if (cur_level == '0) begin
                        r_status <= locd_pkg::ST_MULTI_UNL; r_halted <= 1'b1;
                    end else if (h_rdata != r_lock) begin
                        r_status <= locd_pkg::ST_INV_UNL; r_halted <= 1'b1;
                    end else begin
                        r_status <= locd_pkg::ST_OK;
                        r_level[r_thr] <= cur_level - CW'(1);
                    end
                end
                S_MROW: begin
                    if (m_rdata[r_lock]) r_level[r_thr] <= cur_level + CW'(1);
                    else begin
                        r_edge <= 1'b1; r_root <= '0;
                        r_visited <= '0; r_finished <= '0;
                    end
                end
                S_EDGE: ;
                S_ROOT: begin
                    if (!r_visited[r_root]) begin
                        r_visited[r_root] <= 1'b1;
                        r_here <= r_root; r_depth <= DW'(1);
                    end else if (r_root == LW'(LOCKS - 1)) begin
                        r_level[r_thr] <= cur_level + CW'(1);
                    end else r_root <= r_root + LW'(1);
                end
                S_RD: r_row <= m_rdata;
                S_SCAN: begin
                    if (scan_any && r_visited[scan_idx]) begin
                        r_status <= locd_pkg::ST_DEADLOCK; r_halted <= 1'b1;
                    end else if (scan_any) begin
                        r_visited[scan_idx] <= 1'b1;
                        r_here <= scan_idx;
                        r_depth <= r_depth + DW'(1);
                    end else begin
                        r_finished[r_here] <= 1'b1;
                        r_depth <= r_depth - DW'(1);
                    end
                end
                S_POP: begin
                    if (r_depth == '0) begin
                        if (r_root == LW'(LOCKS - 1))
                            r_level[r_thr] <= cur_level + CW'(1);
                        else r_root <= r_root + LW'(1);
                    end else r_here <= p_rdata;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_held  <= locd_pkg::HELD_W'(cur_level);
                end
                default: ;
            endcase
        end
    end

    // S_POP reads the parent from path RAM: address set while in S_SCAN
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_edge_added = r_edge;
    assign o_held_count = r_held;

endmodule

// ===== sv/locd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locd_checker
// Port-level checks of the lock order cycle detector.
// ----------------------------------------------------------------------------
module locd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic       o_edge_added,
    input logic [4:0] o_held_count
);

    // a transfer always makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept without busy");

    // a result frees the block
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // a halted result never records an edge
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == locd_pkg::ST_HALTED) |-> !o_edge_added)
        else $error("edge while halted");

    // deadlock always comes with a new edge
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == locd_pkg::ST_DEADLOCK) |-> o_edge_added)
        else $error("deadlock without edge");

    // held count never exceeds the stack depth
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_held_count <= 5'(locd_pkg::STACK_DEPTH_DEF)))
        else $error("held count above stack depth");

endmodule

bind lock_order_cycle_detector_unit locd_checker u_locd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_status(o_status), .o_edge_added(o_edge_added),
    .o_held_count(o_held_count));
